// File: sv/sbda_pkg.sv
package sbda_pkg;

   // magnitude width and decimal text limits
   localparam int MagWidth    = 128;
   localparam int NumDigits   = 39;
   localparam int BcdWidth    = 4 * NumDigits;
   localparam int BitsPerStep = 4;
   localparam int ConvSteps   = MagWidth / BitsPerStep;
   localparam int StepWidth   = $clog2(ConvSteps);
   localparam int CountWidth  = $clog2(NumDigits + 1);

   // character codes
   localparam logic [5:0] CodeMinus = 6'd45;
   localparam logic [5:0] CodeZero  = 6'd48;

   // one classified word between front and back
   typedef struct packed {
      logic                neg;
      logic [MagWidth-1:0] mag;
   } item_type;

   // queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// File: sv/sbda_intf.sv
interface sbda_req_if;
   import sbda_pkg::*;

   logic               valid;
   logic               ready;
   logic signed [63:0] value_high;
   logic        [63:0] value_low;

   modport source (output valid, output value_high, output value_low, input ready);
   modport sink   (input valid, input value_high, input value_low, output ready);
endinterface

interface sbda_rsp_if;
   import sbda_pkg::*;

   logic       valid;
   logic       ready;
   logic [5:0] char_code;
   logic       is_last;

   modport source (output valid, output char_code, output is_last, input ready);
   modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

// File: sv/sbda_front.sv
module sbda_front (
   sbda_req_if.sink                 req,
   input  sbda_pkg::queue_status_type status,
   output logic                     push,
   output sbda_pkg::item_type       item
);
   import sbda_pkg::*;

   logic [MagWidth-1:0] raw;

   // accept whenever the queue has room
   assign req.ready = !status.full;
   assign push      = req.valid && !status.full;

   // sign and magnitude; the most negative value maps onto 2^127 unchanged
   assign raw      = {req.value_high, req.value_low};
   assign item.neg = req.value_high[63];
   assign item.mag = req.value_high[63] ? (~raw + {{(MagWidth-1){1'b0}}, 1'b1}) : raw;

endmodule

// File: sv/sbda_fifo.sv
module sbda_fifo (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  sbda_pkg::item_type         push_item,
   input  logic                       pop,
   output sbda_pkg::item_type         head,
   output sbda_pkg::queue_status_type status
);
   import sbda_pkg::*;

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] level_ff, level_in;
   logic       do_push, do_pop;

   assign status.full  = (level_ff == 2'd2);
   assign status.empty = (level_ff == 2'd0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = entry_ff[rd_ptr_ff];

   // pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      level_in  = level_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         level_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: sv/sbda_back.sv
module sbda_back (
   input  logic                       clock,
   input  logic                       reset,
   input  sbda_pkg::item_type         head,
   input  sbda_pkg::queue_status_type status,
   output logic                       pop,
   sbda_rsp_if.source                 rsp
);
   import sbda_pkg::*;

   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StConv = 2'd1;
   localparam logic [1:0] StSign = 2'd2;
   localparam logic [1:0] StEmit = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [MagWidth-1:0]   bin_ff, bin_in;
   logic [BcdWidth-1:0]   bcd_ff, bcd_in;
   logic                  neg_ff, neg_in;
   logic                  started_ff, started_in;
   logic [StepWidth-1:0]  step_ff, step_in;
   logic [CountWidth-1:0] cnt_ff, cnt_in;
   logic                  valid_ff, valid_in;
   logic [5:0]            char_ff, char_in;
   logic                  last_ff, last_in;
   logic                  out_free;
   logic [3:0]            top;

   // shift-add-3 over several input bits, most significant first
   function automatic logic [BcdWidth-1:0] dabble(input logic [BcdWidth-1:0] b,
                                                  input logic [BitsPerStep-1:0] bits);
      logic [BcdWidth-1:0] v;
      v = b;
      for (int s = BitsPerStep - 1; s >= 0; s--) begin
         for (int i = 0; i < NumDigits; i++) begin
            if (v[4*i +: 4] >= 4'd5) begin
               v[4*i +: 4] = v[4*i +: 4] + 4'd3;
            end
         end
         v = {v[BcdWidth-2:0], bits[s]};
      end
      return v;
   endfunction

   assign out_free      = !valid_ff || rsp.ready;
   assign top           = bcd_ff[BcdWidth-1 -: 4];
   assign pop           = (state_ff == StIdle) && !status.empty;
   assign rsp.valid     = valid_ff;
   assign rsp.char_code = char_ff;
   assign rsp.is_last   = last_ff;

   // sequencer: load, convert, sign, emit digits
   always_comb begin
      state_in   = state_ff;
      bin_in     = bin_ff;
      bcd_in     = bcd_ff;
      neg_in     = neg_ff;
      started_in = started_ff;
      step_in    = step_ff;
      cnt_in     = cnt_ff;
      valid_in   = valid_ff && !rsp.ready;
      char_in    = char_ff;
      last_in    = last_ff;
      case (state_ff)
         StIdle: begin
            if (!status.empty) begin
               bin_in     = head.mag;
               neg_in     = head.neg;
               bcd_in     = '0;
               step_in    = '0;
               started_in = 1'b0;
               state_in   = StConv;
            end
         end
         StConv: begin
            bcd_in  = dabble(bcd_ff, bin_ff[MagWidth-1 -: BitsPerStep]);
            bin_in  = {bin_ff[MagWidth-BitsPerStep-1:0], {BitsPerStep{1'b0}}};
            step_in = step_ff + 1'b1;
            if (step_ff == StepWidth'(ConvSteps - 1)) begin
               cnt_in   = CountWidth'(NumDigits);
               state_in = StSign;
            end
         end
         StSign: begin
            if (!neg_ff) begin
               state_in = StEmit;
            end else if (out_free) begin
               valid_in = 1'b1;
               char_in  = CodeMinus;
               last_in  = 1'b0;
               state_in = StEmit;
            end
         end
         StEmit: begin
            if (!started_ff && top == 4'd0 && cnt_ff > CountWidth'(1)) begin
               // drop a leading zero
               bcd_in = {bcd_ff[BcdWidth-5:0], 4'd0};
               cnt_in = cnt_ff - 1'b1;
            end else if (out_free) begin
               valid_in   = 1'b1;
               char_in    = CodeZero + {2'b00, top};
               last_in    = (cnt_ff == CountWidth'(1));
               started_in = 1'b1;
               bcd_in     = {bcd_ff[BcdWidth-5:0], 4'd0};
               cnt_in     = cnt_ff - 1'b1;
               if (cnt_ff == CountWidth'(1)) begin
                  state_in = StIdle;
               end
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   // datapath, no reset
   always_ff @(posedge clock) begin
      bin_ff     <= bin_in;
      bcd_ff     <= bcd_in;
      neg_ff     <= neg_in;
      started_ff <= started_in;
      step_ff    <= step_in;
      cnt_ff     <= cnt_in;
      char_ff    <= char_in;
      last_ff    <= last_in;
   end

endmodule

// File: sv/signed_binary_to_decimal_ascii.sv
// Channel  Dir  Payload                              Word
// req      in   value_high[63:0] s, value_low[63:0]  one 128-bit number
// rsp      out  char_code[5:0], is_last              one ASCII character
//
// In the back end a number is loaded, run through the 4-bit-per-cycle shift-add-3 BCD
// loop, given its sign, and emitted by the one-digit-per-cycle scan of the BCD register
// (leading zeros dropped) while the sink is ready.
// A two-word queue lets req take new numbers while the back end works.
// Reset is synchronous, active high, and empties the queue and the output.
// A stalled rsp holds the scan; req stalls only when the queue is full.
module signed_binary_to_decimal_ascii (
   input logic        clock,
   input logic        reset,
   sbda_req_if.sink   req,
   sbda_rsp_if.source rsp
);
   import sbda_pkg::*;

   item_type         push_item;
   item_type         head;
   queue_status_type status;
   logic             push;
   logic             pop;

   sbda_front u_front (
      .req    (req),
      .status (status),
      .push   (push),
      .item   (push_item)
   );

   sbda_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .status    (status)
   );

   sbda_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .status (status),
      .pop    (pop),
      .rsp    (rsp)
   );

   // never push into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("push into full queue");

   // never pop an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("pop from empty queue");

   // a minus sign is never the last character
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.char_code == CodeMinus) |-> !rsp.is_last)
      else $error("minus flagged last");

   // only minus or a digit leaves
   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.char_code == CodeMinus ||
                     (rsp.char_code >= CodeZero && rsp.char_code <= CodeZero + 6'd9)))
      else $error("bad character code");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import sbda_pkg::*;

   localparam int HalfPeriod  = 6;
   localparam int ResetCycles = 11;
   localparam int NumRandom   = 178;
   localparam int DrainCycles = 100;   // idle wait after all text is back
   localparam int StuckLimit  = 4000;

   // one expected character of the decimal text
   typedef struct packed {
      logic [5:0] char_code;
      logic       is_last;
   } text_char_type;

   // one number waiting to be sent; drain_first holds it until all text is back
   typedef struct {
      logic [127:0] number;
      bit           drain_first;
   } number_job_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sbda_req_if req_ch ();
   sbda_rsp_if rsp_ch ();

   text_char_type  text_due[$];
   number_job_type number_backlog[$];
   int             mismatches = 0;

   // sender and receiver pacing
   int req_gap_left  = 0;
   int req_mode_left = 0;
   bit req_gappy     = 1'b0;
   int rsp_stall_left = 0;
   int rsp_mode_left  = 0;
   bit rsp_gappy      = 1'b0;

   signed_binary_to_decimal_ascii i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always begin
      #(HalfPeriod) clock = 1'b1;
      #(HalfPeriod) clock = 1'b0;
   end

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 80);
   endfunction

   function automatic logic [127:0] pow10(int n);
      logic [127:0] p;
      p = 128'd1;
      for (int i = 0; i < n; i++) p = p * 128'd10;
      return p;
   endfunction

   // decimal text of a signed 128-bit number, appended to text_due
   function automatic void predict_decimal_text(logic [127:0] number);
      logic [127:0]  mag;
      logic [5:0]    digits[$];
      text_char_type ch;
      mag = number[127] ? (128'd0 - number) : number;
      do begin
         digits.push_front(CodeZero + 6'(mag % 128'd10));
         mag = mag / 128'd10;
      end while (mag != 128'd0);
      if (number[127]) begin
         ch.char_code = CodeMinus;
         ch.is_last   = 1'b0;
         text_due = {text_due, ch};
      end
      foreach (digits[i]) begin
         ch.char_code = digits[i];
         ch.is_last   = (i == digits.size() - 1);
         text_due = {text_due, ch};
      end
   endfunction

   // random number of varied magnitude and sign
   function automatic logic [127:0] random_number();
      logic [127:0] raw;
      logic [127:0] v;
      raw = {$urandom, $urandom, $urandom, $urandom};
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            return raw;
         end
         3, 4, 5: begin
            v = raw >> $urandom_range(1, 127);
         end
         6: begin
            v = 128'($urandom_range(0, 999));
         end
         7: begin
            v = pow10($urandom_range(0, 38)) + 128'($urandom_range(0, 2)) - 128'd1;
         end
         8: begin
            // near the two ends of the range
            v = {1'b0, {127{1'b1}}} - 128'($urandom_range(0, 3));
            if ($urandom_range(0, 1)) return 128'd0 - v - 128'd1;
            return v;
         end
         default: begin
            v = {64'd0, raw[63:0]};
         end
      endcase
      if ($urandom_range(0, 1)) v = 128'd0 - v;
      return v;
   endfunction

   task automatic queue_number(logic [127:0] number, bit drain_first);
      number_job_type job;
      job.number      = number;
      job.drain_first = drain_first;
      number_backlog = {number_backlog, job};
   endtask

   // driver: sends numbers from the backlog with random gaps
   always @(posedge clock) begin : req_driver
      number_job_type job;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_mode_left == 0) begin
            req_gappy     = ($urandom_range(0, 3) != 0);
            req_mode_left = $urandom_range(50, 1500);
         end else begin
            req_mode_left--;
         end
         if (req_ch.valid && req_ch.ready) begin
            predict_decimal_text({req_ch.value_high, req_ch.value_low});
            req_gap_left = req_gappy ? pick_gap() : 0;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (req_gap_left > 0) begin
               req_gap_left--;
               req_ch.valid <= 1'b0;
            end else if (number_backlog.size() != 0 &&
                         !(number_backlog[0].drain_first && text_due.size() != 0)) begin
               job = number_backlog.pop_front();
               req_ch.value_high <= job.number[127:64];
               req_ch.value_low  <= job.number[63:0];
               req_ch.valid      <= 1'b1;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: random back-pressure, checks each character word
   always @(posedge clock) begin : rsp_monitor
      text_char_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (text_due.size() == 0) begin
               $display("%0t: unexpected word char_code %0d is_last %0d",
                        $time, rsp_ch.char_code, rsp_ch.is_last);
               mismatches++;
            end else begin
               want = text_due.pop_front();
               if (rsp_ch.char_code !== want.char_code) begin
                  $display("%0t: char_code expected %0d actual %0d",
                           $time, want.char_code, rsp_ch.char_code);
                  mismatches++;
               end
               if (rsp_ch.is_last !== want.is_last) begin
                  $display("%0t: is_last expected %0d actual %0d",
                           $time, want.is_last, rsp_ch.is_last);
                  mismatches++;
               end
            end
         end
         if (rsp_mode_left == 0) begin
            rsp_gappy     = ($urandom_range(0, 2) != 0);
            rsp_mode_left = $urandom_range(50, 800);
         end else begin
            rsp_mode_left--;
         end
         if (rsp_stall_left > 0) begin
            rsp_stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (rsp_gappy && $urandom_range(0, 3) == 0) begin
            rsp_stall_left = pick_gap();
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // watchdog: ends the run when neither side moves a word for too long
   initial begin : watchdog
      int stuck;
      stuck = 0;
      while (stuck < StuckLimit) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stuck = 0;
         else
            stuck++;
      end
      $display("%0t: no progress for %0d cycles", $time, StuckLimit);
      $display("== FAIL ==");
      $finish;
   end

   initial begin : stimulus
      req_ch.valid      = 1'b0;
      req_ch.value_high = '0;
      req_ch.value_low  = '0;
      rsp_ch.ready      = 1'b0;

      // directed: zero, small values, digit-count edges, both range ends
      queue_number(128'd0, 1'b0);
      queue_number(128'd1, 1'b0);
      queue_number(128'd0 - 128'd1, 1'b0);
      queue_number(128'd9, 1'b0);
      queue_number(128'd10, 1'b0);
      queue_number(128'd0 - 128'd9, 1'b0);
      queue_number(128'd0 - 128'd10, 1'b0);
      queue_number(128'd99, 1'b0);
      queue_number(128'd100, 1'b0);
      queue_number(128'd0 - 128'd100, 1'b0);
      queue_number({1'b0, {127{1'b1}}}, 1'b0);
      queue_number({1'b1, 127'd0}, 1'b0);          // most negative: -2^127
      queue_number({1'b1, 126'd0, 1'b1}, 1'b0);
      queue_number(pow10(38), 1'b0);
      queue_number(pow10(38) - 128'd1, 1'b0);
      queue_number(128'd0 - pow10(38), 1'b0);
      queue_number({64'd0, {64{1'b1}}}, 1'b0);
      queue_number({64'd1, 64'd0}, 1'b0);
      queue_number({{64{1'b1}}, 64'd0}, 1'b0);
      queue_number({32{4'h5}}, 1'b0);
      queue_number({32{4'hA}}, 1'b0);
      queue_number(128'h0123456789ABCDEF_FEDCBA9876543210, 1'b0);

      // random numbers; a few wait for all outstanding text first
      for (int n = 0; n < NumRandom; n++)
         queue_number(random_number(), (n == 0 || n == NumRandom / 2 || n == NumRandom - 10));

      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      while (number_backlog.size() != 0 || req_ch.valid) @(posedge clock);
      while (text_due.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
